[hdl/video_controller_register_port_defines.svh]
// Assertion macros used by the checker file of the video controller port.
// No dependencies; include by bare file name.
`ifndef VIDEO_CONTROLLER_REGISTER_PORT_DEFINES_SVH
`define VIDEO_CONTROLLER_REGISTER_PORT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VCRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vcrp_pkg.sv]
// Shared types and constants for the video controller register port.
// No dependencies.
`default_nettype none
package vcrp_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_VSYNC = 2'd2,
    OP_LINE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_SYNC    = 2'd0,
    PH_START   = 2'd1,
    PH_DISPLAY = 2'd2,
    PH_END     = 2'd3
  } phase_t;

  localparam logic [4:0] REG_MAWR = 5'h00;
  localparam logic [4:0] REG_MARR = 5'h01;
  localparam logic [4:0] REG_VRWR = 5'h02;
  localparam logic [4:0] REG_CR   = 5'h05;
  localparam logic [4:0] REG_RCR  = 5'h06;
  localparam logic [4:0] REG_VPR  = 5'h0C;
  localparam logic [4:0] REG_VDW  = 5'h0D;
  localparam logic [4:0] REG_VCR  = 5'h0E;
  localparam logic [4:0] REG_DCR  = 5'h0F;

  localparam logic [5:0] IRQ_RASTER = 6'h04;
  localparam logic [5:0] IRQ_VBLANK = 6'h20;

  localparam logic [9:0] RASTER_RELOAD = 10'd64;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } vram_req_t;

endpackage
`default_nettype wire

[hdl/vcrp_vram.sv]
// Video memory: one write port, one registered read port, clearing sweep after reset.
// Depends on vcrp_pkg.
`default_nettype none
module vcrp_vram #(
  parameter int VRAM_ADDR_BITS = 15
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  vcrp_pkg::vram_req_t            req,
  input  wire logic [VRAM_ADDR_BITS-1:0] addr,
  input  wire logic [15:0]               wdata,
  output logic      [15:0]               rdata,
  output logic                           ready
);
  import vcrp_pkg::*;

  logic [15:0]             mem [2**VRAM_ADDR_BITS];
  logic [VRAM_ADDR_BITS:0] clr_cnt_r;
  logic [15:0]             rdata_r;

  assign ready = clr_cnt_r[VRAM_ADDR_BITS];
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_cnt_r[VRAM_ADDR_BITS]) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr_cnt_r[VRAM_ADDR_BITS]) begin
      mem[clr_cnt_r[VRAM_ADDR_BITS-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem[addr] <= wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[hdl/vcrp_regs.sv]
// Register file, address counters, interrupt and vertical timing logic of the port.
// Depends on vcrp_pkg; drives the request side of vcrp_vram.
`default_nettype none
module vcrp_regs #(
  parameter int VRAM_ADDR_BITS = 15
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [1:0]                opcode,
  input  wire logic [1:0]                port,
  input  wire logic [7:0]                wdata,
  input  wire logic [15:0]               vram_rdata,
  output vcrp_pkg::vram_req_t            vram_req,
  output logic      [VRAM_ADDR_BITS-1:0] vram_addr,
  output logic      [15:0]               vram_wdata,
  output logic                           fetch_busy,
  output logic      [7:0]                res_rdata,
  output logic                           res_irq_line,
  output logic                           res_in_display
);
  import vcrp_pkg::*;

  logic [4:0]  sel_r, sel_nxt;
  logic [15:0] wa_r, wa_nxt;
  logic [15:0] ra_r, ra_nxt;
  logic [15:0] rl_r, rl_nxt;
  logic [15:0] wl_r, wl_nxt;
  logic [7:0]  step_r, step_nxt;
  logic [5:0]  en_r, en_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic [9:0]  rcmp_r, rcmp_nxt;
  logic [4:0]  vsw_r, vsw_nxt;
  logic [7:0]  vds_r, vds_nxt;
  logic [8:0]  vdw_r, vdw_nxt;
  logic [7:0]  vde_r, vde_nxt;
  phase_t      ph_r, ph_nxt;
  logic [9:0]  lo_r, lo_nxt;
  logic [9:0]  rc_r, rc_nxt;
  logic        fetch_r, fetch_nxt;

  logic        hi;
  logic        fetch;
  logic        store;
  logic [15:0] fetch_addr;
  logic [9:0]  lo_inc;

  function automatic logic [15:0] set_byte(input logic [15:0] w, input logic h,
                                           input logic [7:0] b);
    set_byte = h ? {b, w[7:0]} : {w[15:8], b};
  endfunction

  always_comb begin
    sel_nxt = sel_r;   wa_nxt = wa_r;     ra_nxt = ra_r;     rl_nxt = rl_r;
    wl_nxt = wl_r;     step_nxt = step_r; en_nxt = en_r;     pend_nxt = pend_r;
    rcmp_nxt = rcmp_r; vsw_nxt = vsw_r;   vds_nxt = vds_r;   vdw_nxt = vdw_r;
    vde_nxt = vde_r;   ph_nxt = ph_r;     lo_nxt = lo_r;     rc_nxt = rc_r;
    fetch_nxt = 1'b0;
    hi = port[0];
    fetch = 1'b0;
    store = 1'b0;
    fetch_addr = ra_r;
    lo_inc = lo_r + 10'd1;
    res_rdata = '0;

    // land the refill from the previous beat
    if (fetch_r) begin
      rl_nxt = vram_rdata;
    end

    if (accept) begin
      case (op_t'(opcode))
        OP_READ: begin
          if (!port[1]) begin
            if (!hi) begin
              res_rdata = {2'b00, pend_r};
              pend_nxt = '0;
            end
          end else if (sel_r == REG_VRWR) begin
            res_rdata = hi ? rl_r[15:8] : rl_r[7:0];
            if (hi) begin
              ra_nxt = ra_r + {8'h00, step_r};
              fetch = 1'b1;
              fetch_addr = ra_nxt;
            end
          end
        end
        OP_WRITE: begin
          if (!port[1]) begin
            if (!hi) sel_nxt = wdata[4:0];
          end else begin
            case (sel_r)
              REG_MAWR: wa_nxt = set_byte(wa_r, hi, wdata);
              REG_MARR: begin
                ra_nxt = set_byte(ra_r, hi, wdata);
                fetch = 1'b1;
                fetch_addr = ra_nxt;
              end
              REG_VRWR: begin
                wl_nxt = set_byte(wl_r, hi, wdata);
                if (hi) begin
                  store = !wa_r[15];
                  wa_nxt = wa_r + {8'h00, step_r};
                end
              end
              REG_CR: begin
                if (!hi) begin
                  en_nxt = (en_r & 6'h18) | {wdata[3], 2'b00, wdata[2:0]};
                end else begin
                  case (wdata[4:3])
                    2'd0:    step_nxt = 8'h01;
                    2'd1:    step_nxt = 8'h20;
                    2'd2:    step_nxt = 8'h40;
                    default: step_nxt = 8'h80;
                  endcase
                end
              end
              REG_RCR: begin
                if (!hi) rcmp_nxt = {rcmp_r[9:8], wdata};
                else     rcmp_nxt = {wdata[1:0], rcmp_r[7:0]};
              end
              REG_VPR: begin
                if (!hi) vsw_nxt = wdata[4:0];
                else     vds_nxt = wdata;
              end
              REG_VDW: begin
                if (!hi) vdw_nxt = {vdw_r[8], wdata};
                else     vdw_nxt = {wdata[0], vdw_r[7:0]};
              end
              REG_VCR: begin
                if (!hi) vde_nxt = wdata;
              end
              REG_DCR: begin
                if (!hi) en_nxt = (en_r & 6'h27) | {1'b0, wdata[1:0], 3'b000};
              end
              default: ;
            endcase
          end
        end
        OP_VSYNC: begin
          ph_nxt = PH_SYNC;
          lo_nxt = '0;
        end
        default: begin
          if (rc_r == rcmp_r) pend_nxt = pend_nxt | (IRQ_RASTER & en_r);
          rc_nxt = rc_r + 10'd1;
          lo_nxt = lo_inc;
          unique case (ph_r)
            PH_SYNC: begin
              if (lo_inc == {5'd0, vsw_r} + 10'd1) begin
                ph_nxt = PH_START;
                lo_nxt = '0;
              end
            end
            PH_START: begin
              if (lo_inc == {2'd0, vds_r}) begin
                ph_nxt = PH_DISPLAY;
                lo_nxt = '0;
                rc_nxt = RASTER_RELOAD;
              end
            end
            PH_DISPLAY: begin
              if (lo_inc == {1'b0, vdw_r} + 10'd1) begin
                ph_nxt = PH_END;
                lo_nxt = '0;
                pend_nxt = pend_nxt | (IRQ_VBLANK & en_r);
              end
            end
            default: begin
              if (lo_inc == {2'd0, vde_r}) begin
                ph_nxt = PH_SYNC;
                lo_nxt = '0;
              end
            end
          endcase
        end
      endcase
    end

    // high half of the address space reads as zero without touching memory
    if (fetch) begin
      if (fetch_addr[15]) rl_nxt = '0;
      else                fetch_nxt = 1'b1;
    end

    vram_req.wr_en = store;
    vram_req.rd_en = fetch && !fetch_addr[15];
    vram_addr      = store ? wa_r[VRAM_ADDR_BITS-1:0] : fetch_addr[VRAM_ADDR_BITS-1:0];
    vram_wdata     = wl_nxt;

    res_irq_line   = |(pend_nxt & en_nxt);
    res_in_display = (ph_nxt == PH_DISPLAY);
  end

  assign fetch_busy = fetch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;  wa_r <= '0;   ra_r <= '0;   rl_r <= '0;   wl_r <= '0;
      step_r <= '0; en_r <= '0;   pend_r <= '0; rcmp_r <= '0; vsw_r <= '0;
      vds_r <= '0;  vdw_r <= '0;  vde_r <= '0;  ph_r <= PH_SYNC;
      lo_r <= '0;   rc_r <= '0;   fetch_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;   wa_r <= wa_nxt;     ra_r <= ra_nxt;     rl_r <= rl_nxt;
      wl_r <= wl_nxt;     step_r <= step_nxt; en_r <= en_nxt;     pend_r <= pend_nxt;
      rcmp_r <= rcmp_nxt; vsw_r <= vsw_nxt;   vds_r <= vds_nxt;   vdw_r <= vdw_nxt;
      vde_r <= vde_nxt;   ph_r <= ph_nxt;     lo_r <= lo_nxt;     rc_r <= rc_nxt;
      fetch_r <= fetch_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/video_controller_register_port.sv]
// Video controller host port: bus reads and writes, vsync and line events.
// Usage:
//   Input channel in_valid/in_stall carries one event per beat: in_opcode
//   (read, write, vsync, line tick), in_port (data/status, high/low byte)
//   and in_wdata. Each event yields exactly one result beat on
//   out_valid/out_stall: out_rdata, out_irq_line, out_in_display.
//   Latency: the result is shown in the cycle after the event is taken.
//   Throughput: one event per cycle; an event that refills the read latch
//   (high-byte data read, read-address write) from the lower half of the
//   address space holds the input while the memory read port returns the
//   word. Upper-half refills load zero at once.
//   After reset the 2^VRAM_ADDR_BITS-word video memory is swept to zero
//   one word per cycle; in_stall stays high for that sweep.
//   When the receiver stalls, the result register holds and a new event
//   is taken only in a cycle where that register empties.
// Depends on vcrp_pkg, vcrp_regs, vcrp_vram.
`default_nettype none
module video_controller_register_port #(
  parameter int VRAM_ADDR_BITS = 15
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [1:0] in_port,
  input  wire logic [7:0] in_wdata,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_rdata,
  output logic            out_irq_line,
  output logic            out_in_display
);
  import vcrp_pkg::*;

  vram_req_t                 vram_req;
  logic [VRAM_ADDR_BITS-1:0] vram_addr;
  logic [15:0]               vram_wdata;
  logic [15:0]               vram_rdata;
  logic                      vram_ready;
  logic                      fetch_busy;
  logic                      accept;
  logic [7:0]                res_rdata;
  logic                      res_irq_line;
  logic                      res_in_display;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rdata_r;
  logic       out_irq_r;
  logic       out_disp_r;

  assign in_stall = !vram_ready || fetch_busy || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  vcrp_regs #(.VRAM_ADDR_BITS(VRAM_ADDR_BITS)) u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .opcode         (in_opcode),
    .port           (in_port),
    .wdata          (in_wdata),
    .vram_rdata     (vram_rdata),
    .vram_req       (vram_req),
    .vram_addr      (vram_addr),
    .vram_wdata     (vram_wdata),
    .fetch_busy     (fetch_busy),
    .res_rdata      (res_rdata),
    .res_irq_line   (res_irq_line),
    .res_in_display (res_in_display)
  );

  vcrp_vram #(.VRAM_ADDR_BITS(VRAM_ADDR_BITS)) u_vram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (vram_req),
    .addr  (vram_addr),
    .wdata (vram_wdata),
    .rdata (vram_rdata),
    .ready (vram_ready)
  );

  always_comb begin
    if (accept) out_valid_nxt = 1'b1;
    else        out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rdata_r <= res_rdata;
      out_irq_r   <= res_irq_line;
      out_disp_r  <= res_in_display;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rdata      = out_rdata_r;
  assign out_irq_line   = out_irq_r;
  assign out_in_display = out_disp_r;

endmodule
`default_nettype wire

[hdl/vcrp_checker.sv]
// Port-level checks for the video controller register port, bound to the top level.
// Depends on vcrp_pkg and video_controller_register_port_defines.svh.
`default_nettype none
`include "video_controller_register_port_defines.svh"
module vcrp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_opcode,
  input wire logic [1:0] in_port,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_rdata,
  input wire logic       out_irq_line
);
  import vcrp_pkg::*;

  `VCRP_ASSERT_NEXT(a_beat_follows, in_valid && !in_stall, out_valid, "result beat missing")
  `VCRP_ASSERT_NEXT(a_status_clears, in_valid && !in_stall && in_opcode == OP_READ && in_port == 2'd0, !out_irq_line, "irq after status read")
  `VCRP_ASSERT_NEXT(a_nonread_zero, in_valid && !in_stall && in_opcode != OP_READ, out_rdata == 8'h00, "rdata not zero")
  `VCRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rdata), "stalled beat moved")

endmodule

bind video_controller_register_port vcrp_checker u_vcrp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_opcode    (in_opcode),
  .in_port      (in_port),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_rdata    (out_rdata),
  .out_irq_line (out_irq_line)
);
`default_nettype wire
